### hw/rtl/soft_dilation_line_pass_unit_macros.svh
// Assertion macros shared by the soft dilation line pass unit.
// No dependencies; take in with `include inside a module body.
`ifndef SOFT_DILATION_LINE_PASS_UNIT_MACROS_SVH
`define SOFT_DILATION_LINE_PASS_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SDL_ASSERT_IMPLY(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SDL_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("next-cycle check failed");

`endif

### hw/rtl/sdl_pkg.sv
// Types, constants and window functions of the soft dilation line pass unit.
// No dependencies.
package sdl_pkg;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [0:0] REG_CHANNEL_MODE  = 1'b0;
  localparam logic [0:0] REG_INVERT_ENABLE = 1'b1;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    pixel_t pix;
    logic   line_end;
  } out_item_t;

  // c + p - c*p/255 with p = n/4, capped at n; x/255 by reciprocal form.
  function automatic logic [7:0] soften(logic [7:0] c, logic [7:0] n);
    logic [5:0]  p;
    logic [13:0] prod;
    logic [15:0] t;
    logic [7:0]  q;
    logic [8:0]  s;
    p    = n[7:2];
    prod = {6'd0, c} * {8'd0, p};
    t    = {2'b00, prod} + {10'd0, prod[13:8]} + 16'd1;
    q    = t[15:8];
    s    = {1'b0, c} + {3'b000, p} - {1'b0, q};
    return (s > {1'b0, n}) ? n : s[7:0];
  endfunction

  function automatic logic [9:0] rgb_sum(pixel_t px);
    return {2'b00, px.red} + {2'b00, px.green} + {2'b00, px.blue};
  endfunction

  function automatic pixel_t filter_px(pixel_t lraw, pixel_t craw, pixel_t rraw,
                                       logic mode, logic inv);
    pixel_t     l;
    pixel_t     c;
    pixel_t     r;
    pixel_t     n;
    pixel_t     res;
    logic [7:0] na;
    l   = inv ? pixel_t'(~lraw) : lraw;
    c   = inv ? pixel_t'(~craw) : craw;
    r   = inv ? pixel_t'(~rraw) : rraw;
    res = c;
    if (!mode) begin
      n = (rgb_sum(l) < rgb_sum(r)) ? r : l;
      if (rgb_sum(c) < rgb_sum(n)) begin
        res.red   = soften(c.red, n.red);
        res.green = soften(c.green, n.green);
        res.blue  = soften(c.blue, n.blue);
      end
    end else begin
      na = (l.alpha < r.alpha) ? r.alpha : l.alpha;
      if (c.alpha < na) begin
        res.alpha = soften(c.alpha, na);
      end
    end
    return inv ? pixel_t'(~res) : res;
  endfunction

endpackage

### hw/rtl/sdl_in_if.sv
// Input pixel stream of the soft dilation line pass unit.
// No dependencies.
interface sdl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;
  logic       line_end_in;

  modport source(output valid, red_in, green_in, blue_in, alpha_in, line_end_in,
                 input ready);
  modport sink(input valid, red_in, green_in, blue_in, alpha_in, line_end_in,
               output ready);
endinterface

### hw/rtl/sdl_out_if.sv
// Output pixel stream of the soft dilation line pass unit.
// No dependencies.
interface sdl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;
  logic       line_end_out;

  modport source(output valid, red_out, green_out, blue_out, alpha_out, line_end_out,
                 input ready);
  modport sink(input valid, red_out, green_out, blue_out, alpha_out, line_end_out,
               output ready);
endinterface

### hw/rtl/soft_dilation_line_pass_unit.sv
// Top level of the soft dilation line pass unit: 3-tap soft max filter on RGBA8 lines.
// Depends on sdl_pkg, sdl_in_if, sdl_out_if and soft_dilation_line_pass_unit_macros.svh.
//
// Usage:
//   in_ch carries one pixel per beat; line_end_in marks the last pixel of a line.
//   out_ch returns one filtered pixel per beat, in input order, line_end_out on the
//   last one. A pixel leaves once its right neighbour has come in; the last pixel of
//   a line leaves right behind its left neighbour, both caused by the same input beat.
//   Each result is written to the result queue and is shown on out_ch from its head.
//   Throughput: one input beat per cycle while out_ch keeps up. An end-of-line
//   beat pushes two results, so the four-entry result queue takes it only with two
//   free slots; over a line the number of results equals the number of pixels, so
//   the queue keeps pace. The queue also parts the sides: input keeps flowing while
//   a result waits. Receiver stall: results collect in the queue; in_ch.ready drops
//   once fewer than two slots are free, and no beat is lost.
//   Configuration: APB, channel_mode at 0x0, invert_enable at 0x4, pready tied high.
//   Write only while the unit is idle.
//   Reset (rst, synchronous): clears both registers, the window valid flags and
//   the result queue; the next pixel starts a new line.
module soft_dilation_line_pass_unit (
  input  logic                            clk,
  input  logic                            rst,
  sdl_in_if.sink                          in_ch,
  sdl_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sdl_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [sdl_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [sdl_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import sdl_pkg::*;
  `include "soft_dilation_line_pass_unit_macros.svh"

  // Configuration registers.
  logic channel_mode;
  logic invert_enable;

  // Window state: stored as received, before any inversion.
  pixel_t left_pixel;
  pixel_t centre_pixel;
  logic   left_valid;
  logic   centre_valid;

  // Result queue.
  out_item_t              queue [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_ptr;
  logic [OUT_PTR_W-1:0]   rd_ptr;
  logic [OUT_CNT_W-1:0]   fill;

  logic                   in_beat;
  logic                   out_beat;
  logic                   cfg_wr;
  logic [0:0]             reg_index;
  pixel_t                 px;
  pixel_t                 mid_left;
  pixel_t                 tail_left;
  pixel_t                 mid_res;
  pixel_t                 tail_res;
  out_item_t              slot0;
  out_item_t              slot1;
  logic [1:0]             push_cnt;
  logic [OUT_PTR_W-1:0]   wr_ptr_plus1;
  out_item_t              head;

  // APB: writes land in the access phase; reads return the register bit.
  assign pready    = 1'b1;
  assign reg_index = paddr[2:2];
  assign cfg_wr    = psel & penable & pwrite & pready;

  always_comb begin
    prdata = '0;
    case (reg_index)
      REG_CHANNEL_MODE:  prdata[0] = channel_mode;
      REG_INVERT_ENABLE: prdata[0] = invert_enable;
      default:           prdata    = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_mode  <= 1'b0;
      invert_enable <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_index)
        REG_CHANNEL_MODE:  channel_mode  <= pwdata[0];
        REG_INVERT_ENABLE: invert_enable <= pwdata[0];
        default:           ;
      endcase
    end
  end

  // Handshakes: take a beat while two queue slots are free.
  assign in_ch.ready  = (fill <= OUT_CNT_W'(OUT_DEPTH - 2));
  assign in_beat      = in_ch.valid & in_ch.ready;
  assign out_ch.valid = (fill != '0);
  assign out_beat     = out_ch.valid & out_ch.ready;

  assign px = '{alpha: in_ch.alpha_in, blue: in_ch.blue_in,
                green: in_ch.green_in, red: in_ch.red_in};

  // Centre pixel result: right neighbour is the new pixel; at a line start the
  // missing left neighbour is the centre itself.
  assign mid_left = left_valid ? left_pixel : centre_pixel;
  assign mid_res  = filter_px(mid_left, centre_pixel, px, channel_mode, invert_enable);

  // Line end result: the new pixel is its own right neighbour, and its own left
  // one too on a one-pixel line.
  assign tail_left = centre_valid ? centre_pixel : px;
  assign tail_res  = filter_px(tail_left, px, px, channel_mode, invert_enable);

  always_comb begin
    slot1 = '{pix: tail_res, line_end: 1'b1};
    if (centre_valid) begin
      slot0    = '{pix: mid_res, line_end: 1'b0};
      push_cnt = in_ch.line_end_in ? 2'd2 : 2'd1;
    end else begin
      slot0    = slot1;
      push_cnt = in_ch.line_end_in ? 2'd1 : 2'd0;
    end
    if (!in_beat) begin
      push_cnt = 2'd0;
    end
  end

  // Advance the window on every accepted beat; drop it at the line end.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_valid   <= 1'b0;
      centre_valid <= 1'b0;
    end else if (in_beat) begin
      if (in_ch.line_end_in) begin
        left_valid   <= 1'b0;
        centre_valid <= 1'b0;
      end else begin
        left_valid   <= centre_valid;
        centre_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      left_pixel   <= centre_pixel;
      centre_pixel <= px;
    end
  end

  // Result queue: push up to two items, pop one.
  assign wr_ptr_plus1 = wr_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      queue[wr_ptr] <= slot0;
    end
    if (push_cnt == 2'd2) begin
      queue[wr_ptr_plus1] <= slot1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + OUT_PTR_W'(push_cnt);
      if (out_beat) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + OUT_CNT_W'(push_cnt) - OUT_CNT_W'(out_beat);
    end
  end

  // Present the queue head.
  assign head                = queue[rd_ptr];
  assign out_ch.red_out      = head.pix.red;
  assign out_ch.green_out    = head.pix.green;
  assign out_ch.blue_out     = head.pix.blue;
  assign out_ch.alpha_out    = head.pix.alpha;
  assign out_ch.line_end_out = head.line_end;

  // Checks.
  `SDL_ASSERT_IMPLY(a_fill_bound, clk, rst, 1'b1, fill <= OUT_CNT_W'(OUT_DEPTH))
  `SDL_ASSERT_NEXT(a_end_clears_window, clk, rst, in_beat && in_ch.line_end_in,
                   !centre_valid && !left_valid)
  `SDL_ASSERT_NEXT(a_mid_push_one, clk, rst,
                   in_beat && centre_valid && !in_ch.line_end_in && !out_beat,
                   fill == $past(fill) + 1'b1)

endmodule

### tb/soft_dilation_line_pass_unit_test.sv
// Self-checking testbench for the soft dilation line pass unit: directed and random
// pixel lines under every register setting, checked beat by beat against a local model.
// Depends on sdl_pkg, sdl_in_if, sdl_out_if and soft_dilation_line_pass_unit.
module soft_dilation_line_pass_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Channel k of a pixel sits at bits 8k+7:8k: red, green, blue, alpha.
  typedef logic [3:0][7:0] rgba_t;

  typedef struct {
    rgba_t pix;
    bit    last;
  } beat_t;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int CH_ALPHA = 3;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 160;
  localparam int PHASE_BEATS   = 230;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [sdl_pkg::APB_ADDR_W-1:0] paddr;
  logic [sdl_pkg::APB_DATA_W-1:0] pwdata;
  logic [sdl_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  sdl_in_if  in_ch();
  sdl_out_if out_ch();

  soft_dilation_line_pass_unit dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Pixels waiting to be offered, and filtered pixels the block still owes us.
  beat_t line_q[$];
  beat_t due_pixels[$];

  // Local copy of the register file and of the three-tap window.
  bit    mode_alpha;
  bit    invert_on;
  rgba_t left_px;
  rgba_t centre_px;
  bit    left_ok;
  bit    centre_ok;

  int fail_count = 0;
  int cycle_count = 0;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_request;
  bit hold_done;
  int hold_left;

  rgba_t got_px;
  beat_t want_beat;
  beat_t next_beat;

  string chan_names[4] = '{"red", "green", "blue", "alpha"};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Local model of the filter
  // ---------------------------------------------------------------------------

  // Move c toward n by a quarter of n, scaled down as c nears full scale; never past n.
  function automatic logic [7:0] pull_toward(int c, int n);
    int p;
    int v;
    p = n / 4;
    v = c + p - (c * p) / 255;
    return (v > n) ? n[7:0] : v[7:0];
  endfunction

  function automatic int colour_weight(rgba_t x);
    return x[CH_RED] + x[CH_GREEN] + x[CH_BLUE];
  endfunction

  // Filter one centre pixel against its two neighbours, all given as stored.
  function automatic rgba_t dilate_window(rgba_t lraw, rgba_t craw, rgba_t rraw);
    rgba_t l;
    rgba_t c;
    rgba_t r;
    rgba_t n;
    rgba_t res;
    int    na;
    // Inversion turns the soft max into a soft min.
    l   = invert_on ? ~lraw : lraw;
    c   = invert_on ? ~craw : craw;
    r   = invert_on ? ~rraw : rraw;
    res = c;
    if (!mode_alpha) begin
      // Colour mode: brighter neighbour by r+g+b, left wins a tie; alpha rides along.
      n = (colour_weight(l) < colour_weight(r)) ? r : l;
      if (colour_weight(c) < colour_weight(n)) begin
        for (int k = CH_RED; k <= CH_BLUE; k++) begin
          res[k] = pull_toward(c[k], n[k]);
        end
      end
    end else begin
      // Alpha mode: same rule on alpha alone, colour passes through.
      na = (l[CH_ALPHA] < r[CH_ALPHA]) ? r[CH_ALPHA] : l[CH_ALPHA];
      if (c[CH_ALPHA] < na) begin
        res[CH_ALPHA] = pull_toward(c[CH_ALPHA], na);
      end
    end
    return invert_on ? ~res : res;
  endfunction

  // Advance the window by one accepted pixel and queue whatever it lets out.
  task automatic absorb_pixel(rgba_t px, bit last);
    rgba_t lft;
    if (centre_ok) begin
      // The centre now has its right neighbour; a line start uses itself on the left.
      lft = left_ok ? left_px : centre_px;
      due_pixels.push_back('{pix: dilate_window(lft, centre_px, px), last: 1'b0});
      left_px = centre_px;
      left_ok = 1'b1;
    end else begin
      left_ok = 1'b0;
    end
    centre_px = px;
    centre_ok = 1'b1;
    if (last) begin
      // Line end: the pixel is its own right neighbour and leaves right away.
      lft = left_ok ? left_px : px;
      due_pixels.push_back('{pix: dilate_window(lft, px, px), last: 1'b1});
      left_ok   = 1'b0;
      centre_ok = 1'b0;
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic send_px(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
                         bit last);
    line_q.push_back('{pix: {a, b, g, r}, last: last});
  endtask

  // Mostly plain random pixels; some saturated, some dark, some copies of the last
  // one so that ties and equal sums show up.
  function automatic rgba_t random_pixel(rgba_t prev);
    rgba_t v;
    int    kind;
    kind = $urandom_range(0, 9);
    v    = $urandom;
    case (kind)
      0: begin
        for (int k = 0; k < 4; k++) v[k] = $urandom_range(0, 1) ? 8'hff : 8'h00;
      end
      1: v = prev;
      2: begin
        v = prev;
        v[$urandom_range(0, 3)] = 8'($urandom);
      end
      3: begin
        for (int k = 0; k < 4; k++) v[k] = 8'($urandom_range(0, 63));
      end
      default: ;
    endcase
    return v;
  endfunction

  // Queue whole lines until at least the given number of pixels is waiting.
  task automatic random_lines(int count);
    int    len;
    int    pick;
    rgba_t prev;
    prev = '0;
    while (count > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) len = 1;
      else if (pick < 80) len = $urandom_range(2, 8);
      else if (pick < 95) len = $urandom_range(9, 32);
      else len = $urandom_range(33, 64);
      for (int i = 0; i < len; i++) begin
        prev = random_pixel(prev);
        line_q.push_back('{pix: prev, last: (i == len - 1)});
      end
      count -= len;
    end
  endtask

  // APB write, setup phase then access phase; mirror the value at the edge that commits it.
  task automatic write_reg(logic [0:0] idx, bit val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= sdl_pkg::APB_ADDR_W'(idx) << 2;
    pwdata  <= sdl_pkg::APB_DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      sdl_pkg::REG_CHANNEL_MODE:  mode_alpha = val;
      sdl_pkg::REG_INVERT_ENABLE: invert_on  = val;
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // Go back to idle before returning so a following write starts on a fresh edge.
    @(posedge clk);
  endtask

  // Hold until every pixel is in and every owed result is out, then let the
  // pipeline go quiet before touching the registers; look again in case a
  // pixel was picked up at the very edge the queues ran dry.
  task automatic settle();
    do begin
      while (line_q.size() != 0 || in_ch.valid || due_pixels.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end while (line_q.size() != 0 || in_ch.valid || due_pixels.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: offer the next queued pixel, hold it until the block takes it
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid       <= 1'b0;
      in_ch.red_in      <= '0;
      in_ch.green_in    <= '0;
      in_ch.blue_in     <= '0;
      in_ch.alpha_in    <= '0;
      in_ch.line_end_in <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      // The previous beat (if any) went in at this edge; pick what comes next.
      if (line_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_beat            = line_q.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.red_in        <= next_beat.pix[CH_RED];
        in_ch.green_in      <= next_beat.pix[CH_GREEN];
        in_ch.blue_in       <= next_beat.pix[CH_BLUE];
        in_ch.alpha_in      <= next_beat.pix[CH_ALPHA];
        in_ch.line_end_in   <= next_beat.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Input monitor: every accepted beat advances the local window.
  always @(posedge clk) begin
    if (rst) begin
      left_px   = '0;
      centre_px = '0;
      left_ok   = 1'b0;
      centre_ok = 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      absorb_pixel({in_ch.alpha_in, in_ch.blue_in, in_ch.green_in, in_ch.red_in},
                   in_ch.line_end_in);
    end
  end

  // Long receiver hold-off, counted here; asked for once by the main sequence.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Output ready: random stalls, and held low throughout while the hold-off runs.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Output monitor: compare each result beat with the oldest owed pixel.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      got_px = {out_ch.alpha_out, out_ch.blue_out, out_ch.green_out, out_ch.red_out};
      if (due_pixels.size() == 0) begin
        report_mismatch("result with nothing due", got_px, '0);
      end else begin
        want_beat = due_pixels.pop_front();
        for (int k = 0; k < 4; k++) begin
          if (got_px[k] !== want_beat.pix[k]) begin
            report_mismatch(chan_names[k], 32'(got_px[k]), 32'(want_beat.pix[k]));
          end
        end
        if (out_ch.line_end_out !== want_beat.last) begin
          report_mismatch("line_end", 32'(out_ch.line_end_out), 32'(want_beat.last));
        end
      end
    end
  end

  // Watchdog: a stuck handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    mode_alpha        = 1'b0;
    invert_on         = 1'b0;
    hold_request      = 1'b0;
    // Sender rarely idles, receiver mostly stalls.
    send_idle_pct     = 7;
    recv_idle_pct     = 85;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Colour mode, no inversion.
    write_reg(sdl_pkg::REG_CHANNEL_MODE, 1'b0);
    write_reg(sdl_pkg::REG_INVERT_ENABLE, 1'b0);
    // One-pixel lines at both extremes come back unchanged.
    send_px(8'hff, 8'hff, 8'hff, 8'hff, 1'b1);
    send_px(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    // Bright centre between dark edges; the line start sees itself on the left.
    send_px(8'd10, 8'd20, 8'd30, 8'd40, 1'b0);
    send_px(8'hff, 8'hff, 8'hff, 8'hff, 1'b0);
    send_px(8'd100, 8'd100, 8'd100, 8'h00, 1'b1);
    // Equal neighbour sums: the left neighbour wins.
    send_px(8'd200, 8'h00, 8'h00, 8'd9, 1'b0);
    send_px(8'h00, 8'h00, 8'h00, 8'd77, 1'b0);
    send_px(8'h00, 8'h00, 8'd200, 8'd200, 1'b1);
    // Two-pixel line, dark then full white.
    send_px(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    send_px(8'hff, 8'hff, 8'hff, 8'hff, 1'b1);
    settle();

    // Alpha mode: only alpha spreads.
    write_reg(sdl_pkg::REG_CHANNEL_MODE, 1'b1);
    send_px(8'd1, 8'd2, 8'd3, 8'h00, 1'b0);
    send_px(8'd4, 8'd5, 8'd6, 8'd128, 1'b0);
    send_px(8'd7, 8'd8, 8'd9, 8'hff, 1'b1);
    settle();

    // Inverted colour mode: erosion.
    write_reg(sdl_pkg::REG_CHANNEL_MODE, 1'b0);
    write_reg(sdl_pkg::REG_INVERT_ENABLE, 1'b1);
    send_px(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    send_px(8'hff, 8'hff, 8'hff, 8'hff, 1'b0);
    send_px(8'h00, 8'h80, 8'hff, 8'h40, 1'b1);
    settle();

    // Register change inside a line: the held pixel is filtered with the new
    // setting when the closing beat lets it out.
    write_reg(sdl_pkg::REG_INVERT_ENABLE, 1'b0);
    send_px(8'd50, 8'd60, 8'd70, 8'd80, 1'b0);
    send_px(8'd200, 8'd10, 8'd220, 8'd5, 1'b0);
    settle();
    write_reg(sdl_pkg::REG_CHANNEL_MODE, 1'b1);
    send_px(8'd90, 8'd91, 8'd92, 8'd250, 1'b1);
    settle();

    // Random lines, one register setting per phase.
    write_reg(sdl_pkg::REG_CHANNEL_MODE, 1'b0);
    random_lines(PHASE_BEATS);
    settle();

    write_reg(sdl_pkg::REG_CHANNEL_MODE, 1'b1);
    random_lines(PHASE_BEATS);
    settle();

    // Swap the idling: sender mostly idle, receiver rarely stalls.
    send_idle_pct <= 85;
    recv_idle_pct <= 7;
    write_reg(sdl_pkg::REG_CHANNEL_MODE, 1'b0);
    write_reg(sdl_pkg::REG_INVERT_ENABLE, 1'b1);
    random_lines(PHASE_BEATS);
    settle();

    // Full rate both ways, with one long receiver hold-off so the result queue
    // fills and the block has to drop its input ready.
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    write_reg(sdl_pkg::REG_CHANNEL_MODE, 1'b1);
    hold_request <= 1'b1;
    random_lines(PHASE_BEATS);
    settle();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/sdl_pkg.sv
hw/rtl/sdl_in_if.sv
hw/rtl/sdl_out_if.sv
hw/rtl/soft_dilation_line_pass_unit.sv
tb/soft_dilation_line_pass_unit_test.sv
